// ----- sv/text_console_cursor_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Text console cursor engine assertion macros
// Clocked on clk; the reset-gated form is used for state checks.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// check gated by reset
`define TCCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define TCCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Character codes, operation kinds, command codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int ROW_LIMIT   = 128;
  localparam int TAB_SPACES  = 4;

  localparam int LIM_COLS = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int LIM_ROWS = (ROW_LIMIT < 128) ? ROW_LIMIT : 128;
  localparam int TAB_W    = $clog2(TAB_SPACES + 1);

  localparam logic [15:0] CH_BS    = 16'd8;
  localparam logic [15:0] CH_TAB   = 16'd9;
  localparam logic [15:0] CH_NL    = 16'd10;
  localparam logic [15:0] CH_VT    = 16'd11;
  localparam logic [15:0] CH_FF    = 16'd12;
  localparam logic [15:0] CH_CR    = 16'd13;
  localparam logic [15:0] CH_SPACE = 16'd32;

  localparam logic [2:0] K_PUT = 3'd0;
  localparam logic [2:0] K_NL  = 3'd1;
  localparam logic [2:0] K_BS  = 3'd2;
  localparam logic [2:0] K_VT  = 3'd3;
  localparam logic [2:0] K_FF  = 3'd4;
  localparam logic [2:0] K_CR  = 3'd5;

  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] REG_TEXT_COLOR = 2'd0;
  localparam logic [1:0] REG_BACK_COLOR = 2'd1;
  localparam logic [1:0] REG_COLUMNS    = 2'd2;
  localparam logic [1:0] REG_ROWS       = 2'd3;

  typedef struct packed {
    logic [2:0]       kind;
    logic [15:0]      glyph;
    logic [TAB_W-1:0] count;
  } op_t;

  typedef struct packed {
    logic [23:0] text_color;
    logic [23:0] back_color;
    logic [8:0]  cols;
    logic [7:0]  rows;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  cell_column;
    logic [6:0]  cell_row;
    logic [15:0] glyph;
    logic [23:0] glyph_color;
    logic [23:0] cell_back_color;
    logic        last;
  } word_t;

endpackage

`default_nettype wire

// ----- sv/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine
// Turns a stream of character codes into framebuffer cell commands.
// ----------------------------------------------------------------------------
// Input channel: one character code per word (in_valid / in_stall).
// Output channel: one cell command per word (out_valid / out_stall); the last
// bit marks the final command caused by a character.
// Configuration: APB-style write port, colors and screen geometry at byte
// addresses 0, 4, 8 and 12; write only while the engine is idle.
// Path: the first command of an accepted character passes through the queue
// and then the output word register. A two-entry queue decouples decoder and sequencer.
// Throughput: the sequencer emits one command per cycle while operations are
// queued and the receiver does not stall. A printable character gives a draw,
// and a scroll as well when it wraps off the bottom row; newline and backspace
// give up to two commands, a tab up to 8 (a draw and a scroll per space); codes
// without commands: carriage return, backspace at home, vertical tab above the bottom row.
// Reset: cursor at column 0, row 0, queue empty, registers at defaults.
// When the receiver stalls the output word holds, the sequencer waits and
// the input stalls once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_char_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_command,
  output logic [7:0]       out_cell_column,
  output logic [6:0]       out_cell_row,
  output logic [15:0]      out_glyph,
  output logic [23:0]      out_glyph_color,
  output logic [23:0]      out_cell_back_color,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcce_pkg::*;

  logic [23:0] text_color_r;
  logic [23:0] back_color_r;
  logic [8:0]  cols_r;
  logic [7:0]  rows_r;
  logic        wr_en;
  cfg_t        cfg;
  logic        q_full;
  logic        q_push;
  op_t         q_op;
  logic        q_pop;
  logic        head_valid;
  op_t         head_op;
  word_t       word;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= 24'hFF_FFFF;
      back_color_r <= 24'h00_0000;
      cols_r       <= 9'd128;
      rows_r       <= 8'd48;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_TEXT_COLOR: text_color_r <= pwdata[23:0];
        REG_BACK_COLOR: back_color_r <= pwdata[23:0];
        REG_COLUMNS:    cols_r       <= pwdata[8:0];
        REG_ROWS:       rows_r       <= pwdata[7:0];
        default:        cols_r       <= cols_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TEXT_COLOR: prdata = {8'd0, text_color_r};
      REG_BACK_COLOR: prdata = {8'd0, back_color_r};
      REG_COLUMNS:    prdata = {23'd0, cols_r};
      REG_ROWS:       prdata = {24'd0, rows_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.text_color = text_color_r;
    cfg.back_color = back_color_r;
    if (cols_r == 9'd0) begin
      cfg.cols = 9'd1;
    end else if (cols_r > 9'(LIM_COLS)) begin
      cfg.cols = 9'(LIM_COLS);
    end else begin
      cfg.cols = cols_r;
    end
    if (rows_r == 8'd0) begin
      cfg.rows = 8'd1;
    end else if (rows_r > 8'(LIM_ROWS)) begin
      cfg.rows = 8'(LIM_ROWS);
    end else begin
      cfg.rows = rows_r;
    end
  end

  tcce_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (q_op)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_op),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  tcce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (word)
  );

  assign out_command         = word.command;
  assign out_cell_column     = word.cell_column;
  assign out_cell_row        = word.cell_row;
  assign out_glyph           = word.glyph;
  assign out_glyph_color     = word.glyph_color;
  assign out_cell_back_color = word.cell_back_color;
  assign out_last            = word.last;

endmodule

`default_nettype wire

// ----- sv/tcce_front.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine front end
// Accepts character words and decodes them into queued operations.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_front (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_char_code,
  input  wire logic        q_full,
  output logic             q_push,
  output tcce_pkg::op_t    q_op
);
  import tcce_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_op.kind  = K_PUT;
    q_op.glyph = in_char_code;
    q_op.count = TAB_W'(1);
    case (in_char_code)
      CH_NL: begin
        q_op.kind  = K_NL;
        q_op.count = '0;
      end
      CH_BS: begin
        q_op.kind  = K_BS;
        q_op.count = '0;
      end
      CH_TAB: begin
        q_op.glyph = CH_SPACE;
        q_op.count = TAB_W'(TAB_SPACES);
      end
      CH_VT: begin
        q_op.kind  = K_VT;
        q_op.count = '0;
      end
      CH_FF: begin
        q_op.kind  = K_FF;
        q_op.count = '0;
      end
      CH_CR: begin
        q_op.kind  = K_CR;
        q_op.count = '0;
      end
      default: begin
        q_op.kind = K_PUT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tcce_queue.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine operation queue
// Two-entry queue between decoder and command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcce_pkg::op_t push_op,
  input  wire logic          pop,
  output logic               full,
  output logic               head_valid,
  output tcce_pkg::op_t      head_op
);
  import tcce_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_op    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tcce_back.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine command sequencer
// Holds the cursor, runs queued operations and registers output words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cursor_engine_defines.svh"

module tcce_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tcce_pkg::cfg_t cfg,
  input  wire logic           head_valid,
  input  wire tcce_pkg::op_t  head_op,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tcce_pkg::word_t     out_word
);
  import tcce_pkg::*;

  logic [7:0]       col_r, col_nxt;
  logic [6:0]       row_r, row_nxt;
  logic             sp_r, sp_nxt;
  logic             bs_r, bs_nxt;
  logic [TAB_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  word_t            word_r;

  logic             slot_free;
  logic             fire;
  logic             emit;
  logic             done;
  word_t            w;
  logic [7:0]       c;
  logic [6:0]       r;
  logic [8:0]       cols_m1;
  logic [7:0]       rows_m1;
  logic             col_wrap;
  logic             row_wrap;

  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = head_valid && slot_free;
  assign pop       = fire && done;
  assign out_valid = out_valid_r;
  assign out_word  = word_r;

  // cursor seen through the current geometry
  always_comb begin
    cols_m1  = cfg.cols - 9'd1;
    rows_m1  = cfg.rows - 8'd1;
    c        = ({1'b0, col_r} >= cfg.cols) ? cols_m1[7:0] : col_r;
    r        = ({1'b0, row_r} >= cfg.rows) ? rows_m1[6:0] : row_r;
    col_wrap = ({1'b0, c} + 9'd1) >= cfg.cols;
    row_wrap = ({1'b0, r} + 8'd1) >= cfg.rows;
  end

  always_comb begin
    logic more;
    more              = 1'b0;
    emit              = 1'b0;
    done              = 1'b0;
    w.command         = CMD_DRAW;
    w.cell_column     = c;
    w.cell_row        = r;
    w.glyph           = CH_SPACE;
    w.glyph_color     = cfg.back_color;
    w.cell_back_color = cfg.back_color;
    w.last            = 1'b0;
    col_nxt           = col_r;
    row_nxt           = row_r;
    sp_nxt            = sp_r;
    bs_nxt            = bs_r;
    cnt_nxt           = cnt_r;
    if (sp_r) begin
      emit          = 1'b1;
      w.command     = CMD_SCROLL;
      w.cell_column = 8'd0;
      w.cell_row    = rows_m1[6:0];
      row_nxt       = rows_m1[6:0];
      sp_nxt        = 1'b0;
      more          = (head_op.kind == K_PUT) && (cnt_r != head_op.count);
      w.last        = !more;
      done          = !more;
    end else begin
      case (head_op.kind)
        K_PUT: begin
          emit          = 1'b1;
          w.glyph       = head_op.glyph;
          w.glyph_color = cfg.text_color;
          cnt_nxt       = cnt_r + TAB_W'(1);
          col_nxt       = c + 8'd1;
          row_nxt       = r;
          if (col_wrap) begin
            col_nxt = 8'd0;
            if (row_wrap) begin
              sp_nxt = 1'b1;
            end else begin
              row_nxt = r + 7'd1;
            end
          end
          more   = sp_nxt || (cnt_nxt != head_op.count);
          w.last = !more;
          done   = !more;
        end
        K_NL: begin
          emit      = 1'b1;
          w.command = CMD_FILL;
          col_nxt   = 8'd0;
          row_nxt   = r;
          if (row_wrap) begin
            sp_nxt = 1'b1;
          end else begin
            row_nxt = r + 7'd1;
            w.last  = 1'b1;
            done    = 1'b1;
          end
        end
        K_VT: begin
          col_nxt = c;
          done    = 1'b1;
          if (row_wrap) begin
            emit          = 1'b1;
            w.command     = CMD_SCROLL;
            w.cell_column = 8'd0;
            w.cell_row    = rows_m1[6:0];
            w.last        = 1'b1;
            row_nxt       = rows_m1[6:0];
          end else begin
            row_nxt = r + 7'd1;
          end
        end
        K_FF: begin
          emit          = 1'b1;
          w.command     = CMD_CLEAR;
          w.cell_column = 8'd0;
          w.cell_row    = 7'd0;
          w.last        = 1'b1;
          done          = 1'b1;
          col_nxt       = 8'd0;
          row_nxt       = 7'd0;
        end
        K_CR: begin
          col_nxt = 8'd0;
          row_nxt = r;
          done    = 1'b1;
        end
        K_BS: begin
          if (bs_r) begin
            emit   = 1'b1;
            w.last = 1'b1;
            done   = 1'b1;
            bs_nxt = 1'b0;
          end else if (c != 8'd0) begin
            emit      = 1'b1;
            w.command = CMD_FILL;
            col_nxt   = c - 8'd1;
            row_nxt   = r;
            bs_nxt    = 1'b1;
          end else if (r != 7'd0) begin
            emit          = 1'b1;
            row_nxt       = r - 7'd1;
            col_nxt       = cols_m1[7:0];
            w.cell_column = cols_m1[7:0];
            w.cell_row    = r - 7'd1;
            w.last        = 1'b1;
            done          = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    if (done) begin
      cnt_nxt = '0;
      bs_nxt  = 1'b0;
      sp_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 8'd0;
      row_r       <= 7'd0;
      sp_r        <= 1'b0;
      bs_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        sp_r  <= sp_nxt;
        bs_r  <= bs_nxt;
        cnt_r <= cnt_nxt;
      end
      if (slot_free) begin
        out_valid_r <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      word_r <= w;
    end
  end

  `TCCE_ASSERT(a_scroll_row, sp_r |-> (r == rows_m1[6:0]), "pending scroll off bottom row")
  `TCCE_ASSERT(a_bs_head, bs_r |-> (head_valid && head_op.kind == K_BS), "backspace phase lost op")
  `TCCE_ASSERT(a_last_pop, (fire && emit) |-> (w.last == done), "last flag out of step")
  `TCCE_ASSERT(a_phase_excl, !(sp_r && bs_r), "scroll and backspace phases overlap")

endmodule

`default_nettype wire
